>>> rtl/core/pds_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider solver package
// Shared widths, register indexes, reset values and serial ALU types.
// ----------------------------------------------------------------------------
package pds_pkg;

  // rates and limits
  localparam int unsigned RATE_W     = 32;   // Hz fields
  localparam int unsigned KHZ_W      = 23;   // a 32-bit Hz value in kHz
  localparam int unsigned LIM_W      = 22;   // VCO limit registers
  localparam int unsigned STEP_W     = 20;   // reference step register
  localparam int unsigned VCO_W      = 25;   // 22-bit rate times post divider
  localparam int unsigned GSH_W      = 5;    // common power of two in gcd
  localparam int unsigned POST_W     = 3;
  localparam int unsigned POST_DIV_MAX = 7;
  localparam int unsigned KHZ_FACTOR = 1000;
  localparam int unsigned SAT_KHZ    = 4294967;  // largest kHz that fits in Hz

  // default output field widths
  localparam int unsigned FRAC_WIDTH_DEF    = 24;
  localparam int unsigned FB_DIV_WIDTH_DEF  = 11;
  localparam int unsigned REF_DIV_WIDTH_DEF = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_STEP = 2'd2;

  localparam logic [LIM_W-1:0]  VCO_LOW_RST  = 22'd800000;
  localparam logic [LIM_W-1:0]  VCO_HIGH_RST = 22'd3200000;
  localparam logic [STEP_W-1:0] REF_STEP_RST = 20'd20000;

  // serial ALU
  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

>>> rtl/core/pds_in_if.sv
// ----------------------------------------------------------------------------
// PLL divider solver request channel
// Valid/ready channel carrying a target rate and a reference rate in Hz.
// ----------------------------------------------------------------------------
interface pds_in_if import pds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] target_rate_hz;
  logic [RATE_W-1:0] ref_rate_hz;

  modport source (output valid, target_rate_hz, ref_rate_hz, input ready);
  modport sink   (input valid, target_rate_hz, ref_rate_hz, output ready);
endinterface

>>> rtl/core/pds_out_if.sv
// ----------------------------------------------------------------------------
// PLL divider solver result channel
// Valid/ready channel carrying the solved dividers and achieved rate.
// ----------------------------------------------------------------------------
interface pds_out_if import pds_pkg::*;
#(
  parameter int unsigned FRAC_WIDTH    = FRAC_WIDTH_DEF,
  parameter int unsigned FB_DIV_WIDTH  = FB_DIV_WIDTH_DEF,
  parameter int unsigned REF_DIV_WIDTH = REF_DIV_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic [POST_W-1:0]        post_div;
  logic [FB_DIV_WIDTH-1:0]  fb_div;
  logic [REF_DIV_WIDTH-1:0] ref_div;
  logic [FRAC_WIDTH-1:0]    frac_part;
  logic                     frac_mode;
  logic [RATE_W-1:0]        achieved_rate_hz;

  modport source (output valid, status, post_div, fb_div, ref_div, frac_part, frac_mode,
                  achieved_rate_hz, input ready);
  modport sink   (input valid, status, post_div, fb_div, ref_div, frac_part, frac_mode,
                  achieved_rate_hz, output ready);
endinterface

>>> rtl/core/pds_serial_alu.sv
// ----------------------------------------------------------------------------
// PLL divider solver serial ALU
// Bit-serial restoring divider and shift-add multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module pds_serial_alu import pds_pkg::*;
#(
  parameter int unsigned AW = 49
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alu_ctrl_t     ctrl_i,
  input  logic [AW-1:0] a_i,
  input  logic [AW-1:0] b_i,
  output alu_stat_t     stat_o,
  output logic [AW-1:0] q_o,   // quotient
  output logic [AW-1:0] r_o    // remainder or product
);

  localparam int unsigned CW = $clog2(AW + 1);

  alu_op_e       op_q;
  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] q_q, r_q, m_q;

  logic [AW:0]   trial;
  logic          fits;
  logic [AW:0]   diff;
  logic [AW-1:0] madd;

  assign trial = {r_q, q_q[AW-1]};
  assign fits  = trial >= {1'b0, m_q};
  assign diff  = trial - {1'b0, m_q};
  assign madd  = r_q + (q_q[0] ? m_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_DIV;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(AW);
        op_q   <= ctrl_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      q_q <= a_i;
      r_q <= '0;
      m_q <= b_i;
    end else if (busy_q) begin
      if (op_q == ALU_DIV) begin
        r_q <= fits ? diff[AW-1:0] : trial[AW-1:0];
        q_q <= {q_q[AW-2:0], fits};
      end else begin
        r_q <= madd;
        q_q <= q_q >> 1;
        m_q <= m_q << 1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign q_o = q_q;
  assign r_o = r_q;

endmodule

>>> rtl/core/pll_divider_solver.sv
// ----------------------------------------------------------------------------
// PLL divider solver
// Finds post, feedback and reference dividers plus a fraction for a rate.
// ----------------------------------------------------------------------------
// Requests arrive on in_i as one beat with the target and reference rate in
// Hz; one result beat per request leaves on out_o. Status 1 flags a request
// that cannot be reached, with all other fields zero. The three limit
// registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write them only while idle, which the block itself does not enforce. One
// request is worked at a time; in_i.ready is high only while idle. The work
// runs on one bit-serial ALU of AW bits for every multiply and divide
// (AW = 25 + max(FRAC_WIDTH, FB_DIV_WIDTH+REF_DIV_WIDTH), 49 by default),
// plus a binary gcd. An integer solution takes 10 ALU operations, or 11
// when a post divider is needed; a fractional one takes 13, or 14, plus one
// per doubling of the reference divider.
// The result sits in an output register; a new request is taken while it
// waits, and the solver holds its next result until the receiver takes the
// previous beat. Reset clears the channels and loads the limit registers
// with 800000 kHz, 3200000 kHz and 20000 kHz.
// ----------------------------------------------------------------------------
module pll_divider_solver import pds_pkg::*;
#(
  parameter int unsigned FRAC_WIDTH    = FRAC_WIDTH_DEF,
  parameter int unsigned FB_DIV_WIDTH  = FB_DIV_WIDTH_DEF,
  parameter int unsigned REF_DIV_WIDTH = REF_DIV_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pds_in_if.sink                in_i,
  pds_out_if.source             out_o
);

  localparam int unsigned AW = VCO_W + ((FRAC_WIDTH > FB_DIV_WIDTH + REF_DIV_WIDTH) ?
                                        FRAC_WIDTH : FB_DIV_WIDTH + REF_DIV_WIDTH);
  localparam int unsigned DNF_W = FB_DIV_WIDTH + REF_DIV_WIDTH;
  localparam int unsigned KW    = $clog2(REF_DIV_WIDTH);
  localparam int unsigned STK_W = STEP_W + REF_DIV_WIDTH;

  localparam logic [AW-1:0]            FB_MAX_A   = AW'((1 << FB_DIV_WIDTH) - 1);
  localparam logic [AW-1:0]            FB_HALF_A  = AW'(((1 << FB_DIV_WIDTH) - 1) / 2);
  localparam logic [VCO_W-1:0]         FB_MAX_V   = VCO_W'((1 << FB_DIV_WIDTH) - 1);
  localparam logic [KHZ_W-1:0]         REF_MAX_K  = KHZ_W'((1 << REF_DIV_WIDTH) - 1);
  localparam logic [REF_DIV_WIDTH-1:0] REF_HALF_R =
    REF_DIV_WIDTH'(((1 << REF_DIV_WIDTH) - 1) / 2);
  localparam logic [AW-1:0]            SAT_A      = AW'(SAT_KHZ);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CALL = 5'd1;
  localparam logic [4:0] S_WAIT = 5'd2;
  localparam logic [4:0] S_RATE = 5'd3;
  localparam logic [4:0] S_REF  = 5'd4;
  localparam logic [4:0] S_DP   = 5'd5;
  localparam logic [4:0] S_GCD  = 5'd6;
  localparam logic [4:0] S_DN   = 5'd7;
  localparam logic [4:0] S_DM   = 5'd8;
  localparam logic [4:0] S_CHK  = 5'd9;
  localparam logic [4:0] S_DBL  = 5'd10;
  localparam logic [4:0] S_FRAC = 5'd11;
  localparam logic [4:0] S_A1   = 5'd12;
  localparam logic [4:0] S_A2   = 5'd13;
  localparam logic [4:0] S_A3   = 5'd14;
  localparam logic [4:0] S_A4   = 5'd15;
  localparam logic [4:0] S_A5   = 5'd16;
  localparam logic [4:0] S_A6   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  // limit registers
  logic [LIM_W-1:0]  low_q, high_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= VCO_LOW_RST;
      high_q <= VCO_HIGH_RST;
      step_q <= REF_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VCO_LOW:  low_q  <= cfg_data_i[LIM_W-1:0];
        CFG_VCO_HIGH: high_q <= cfg_data_i[LIM_W-1:0];
        CFG_REF_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [4:0] state_q, state_d, ret_q, ret_d;
  alu_op_e    opm_q, opm_d;
  logic [AW-1:0] opa_q, opa_d, opb_q, opb_d;
  logic [RATE_W-1:0] refraw_q, refraw_d;
  logic [KHZ_W-1:0] rate_q, rate_d, refk_q, refk_d, dm_q, dm_d;
  logic [POST_W-1:0] dp_q, dp_d, dp_n;
  logic [VCO_W-1:0] vco_q, vco_d, vco_n, ga_q, ga_d, gb_q, gb_d, dn_q, dn_d, g_n;
  logic [GSH_W-1:0] sh_q, sh_d;
  logic [KW-1:0] k_q, k_d;
  logic [DNF_W-1:0] dnf_q, dnf_d;
  logic [REF_DIV_WIDTH-1:0] dmf_q, dmf_d, dmt;
  logic [FRAC_WIDTH-1:0] frac_q, frac_d;
  logic [AW-1:0] acc_q, acc_d, sum;
  logic [RATE_W-1:0] ach_q, ach_d;
  logic rej_q, rej_d;
  logic [STK_W-1:0] stepk;
  logic dbl_go;

  // result register
  logic                     ov_q, ov_d, ost_q, ost_d, ofm_q, ofm_d;
  logic [POST_W-1:0]        opd_q, opd_d;
  logic [FB_DIV_WIDTH-1:0]  ofb_q, ofb_d;
  logic [REF_DIV_WIDTH-1:0] orf_q, orf_d;
  logic [FRAC_WIDTH-1:0]    ofr_q, ofr_d;
  logic [RATE_W-1:0]        oach_q, oach_d;

  alu_ctrl_t     alu_ctrl;
  alu_stat_t     alu_stat;
  logic [AW-1:0] alu_q, alu_r;

  assign alu_ctrl.start = (state_q == S_CALL);
  assign alu_ctrl.op    = opm_q;

  pds_serial_alu #(.AW(AW)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (opa_q),
    .b_i    (opb_q),
    .stat_o (alu_stat),
    .q_o    (alu_q),
    .r_o    (alu_r)
  );

  assign dp_n   = alu_q[POST_W-1:0] + 1'b1;
  assign vco_n  = VCO_W'(rate_q) * VCO_W'(dp_n);
  assign g_n    = (ga_q == '0) ? (gb_q << sh_q) : (ga_q << sh_q);
  assign dmt    = REF_DIV_WIDTH'(1) << k_q;
  assign stepk  = STK_W'(step_q) << k_q;
  assign dbl_go = (dmt < REF_HALF_R) && (alu_q < FB_HALF_A) &&
                  (STK_W'(refk_q) >= stepk);
  assign sum    = acc_q + (alu_q >> FRAC_WIDTH);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    opm_d    = opm_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    refraw_d = refraw_q;
    rate_d   = rate_q;
    refk_d   = refk_q;
    dm_d     = dm_q;
    dp_d     = dp_q;
    vco_d    = vco_q;
    ga_d     = ga_q;
    gb_d     = gb_q;
    dn_d     = dn_q;
    sh_d     = sh_q;
    k_d      = k_q;
    dnf_d    = dnf_q;
    dmf_d    = dmf_q;
    frac_d   = frac_q;
    acc_d    = acc_q;
    ach_d    = ach_q;
    rej_d    = rej_q;
    ov_d     = ov_q;
    ost_d    = ost_q;
    ofm_d    = ofm_q;
    opd_d    = opd_q;
    ofb_d    = ofb_q;
    orf_d    = orf_q;
    ofr_d    = ofr_q;
    oach_d   = oach_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          refraw_d = in_i.ref_rate_hz;
          rej_d    = 1'b0;
          opm_d    = ALU_DIV;
          opa_d    = AW'(in_i.target_rate_hz);
          opb_d    = AW'(KHZ_FACTOR);
          ret_d    = S_RATE;
          state_d  = S_CALL;
        end
      end
      S_CALL: state_d = S_WAIT;
      S_WAIT: begin
        if (alu_stat.done) begin
          state_d = ret_q;
        end
      end
      S_RATE: begin
        rate_d  = alu_q[KHZ_W-1:0];
        opm_d   = ALU_DIV;
        opa_d   = AW'(refraw_q);
        opb_d   = AW'(KHZ_FACTOR);
        ret_d   = S_REF;
        state_d = S_CALL;
      end
      S_REF: begin
        refk_d = alu_q[KHZ_W-1:0];
        if (rate_q == '0 || refk_d == '0 || rate_q > KHZ_W'(high_q)) begin
          rej_d   = 1'b1;
          state_d = S_DONE;
        end else if (rate_q < KHZ_W'(low_q)) begin
          opm_d   = ALU_DIV;
          opa_d   = AW'(low_q);
          opb_d   = AW'(rate_q);
          ret_d   = S_DP;
          state_d = S_CALL;
        end else begin
          dp_d    = POST_W'(1);
          vco_d   = VCO_W'(rate_q);
          ga_d    = VCO_W'(rate_q);
          gb_d    = VCO_W'(refk_d);
          sh_d    = '0;
          state_d = S_GCD;
        end
      end
      S_DP: begin
        if (alu_q >= AW'(POST_DIV_MAX)) begin
          rej_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          dp_d    = dp_n;
          vco_d   = vco_n;
          ga_d    = vco_n;
          gb_d    = VCO_W'(refk_q);
          sh_d    = '0;
          state_d = S_GCD;
        end
      end
      // binary gcd, one subtract or shift per cycle
      S_GCD: begin
        if (ga_q == '0 || gb_q == '0) begin
          ga_d    = g_n;
          opm_d   = ALU_DIV;
          opa_d   = AW'(vco_q);
          opb_d   = AW'(g_n);
          ret_d   = S_DN;
          state_d = S_CALL;
        end else if (!ga_q[0] && !gb_q[0]) begin
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          sh_d = sh_q + 1'b1;
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (ga_q >= gb_q) begin
          ga_d = ga_q - gb_q;
        end else begin
          gb_d = gb_q - ga_q;
        end
      end
      S_DN: begin
        dn_d    = alu_q[VCO_W-1:0];
        opm_d   = ALU_DIV;
        opa_d   = AW'(refk_q);
        opb_d   = AW'(ga_q);
        ret_d   = S_DM;
        state_d = S_CALL;
      end
      S_DM: begin
        dm_d    = alu_q[KHZ_W-1:0];
        state_d = S_CALL;
        if (dm_d > REF_MAX_K || dn_q > FB_MAX_V) begin
          opm_d = ALU_DIV;
          opa_d = AW'(dn_q);
          opb_d = AW'(dm_d);
          ret_d = S_CHK;
        end else begin
          dnf_d  = DNF_W'(dn_q);
          dmf_d  = REF_DIV_WIDTH'(dm_d);
          frac_d = '0;
          opm_d  = ALU_MUL;
          opa_d  = AW'(refk_q);
          opb_d  = AW'(dn_q);
          ret_d  = S_A1;
        end
      end
      S_CHK: begin
        if (alu_q > FB_MAX_A) begin
          rej_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          k_d     = '0;
          opm_d   = ALU_DIV;
          opa_d   = AW'(dn_q);
          opb_d   = AW'(dm_q);
          ret_d   = S_DBL;
          state_d = S_CALL;
        end
      end
      // alu holds dn*dmt / dm and its remainder
      S_DBL: begin
        opm_d   = ALU_DIV;
        opb_d   = AW'(dm_q);
        state_d = S_CALL;
        if (dbl_go) begin
          k_d   = k_q + 1'b1;
          opa_d = AW'(dn_q) << (k_q + 1'b1);
          ret_d = S_DBL;
        end else begin
          dnf_d = alu_q[DNF_W-1:0];
          dmf_d = dmt;
          opa_d = alu_r << FRAC_WIDTH;
          ret_d = S_FRAC;
        end
      end
      S_FRAC: begin
        frac_d  = alu_q[FRAC_WIDTH-1:0];
        opm_d   = ALU_MUL;
        opa_d   = AW'(refk_q);
        opb_d   = AW'(dnf_q);
        ret_d   = S_A1;
        state_d = S_CALL;
      end
      S_A1: begin
        opm_d   = ALU_DIV;
        opa_d   = alu_r;
        opb_d   = AW'(dmf_q);
        ret_d   = S_A2;
        state_d = S_CALL;
      end
      S_A2: begin
        opm_d   = ALU_DIV;
        opa_d   = alu_q;
        opb_d   = AW'(dp_q);
        ret_d   = S_A3;
        state_d = S_CALL;
      end
      S_A3: begin
        acc_d   = alu_q;
        opm_d   = ALU_MUL;
        opa_d   = AW'(refk_q);
        opb_d   = AW'(frac_q);
        ret_d   = S_A4;
        state_d = S_CALL;
      end
      S_A4: begin
        opm_d   = ALU_DIV;
        opa_d   = alu_r;
        opb_d   = AW'(dmf_q);
        ret_d   = S_A5;
        state_d = S_CALL;
      end
      S_A5: begin
        opm_d   = ALU_DIV;
        opa_d   = alu_q;
        opb_d   = AW'(dp_q);
        ret_d   = S_A6;
        state_d = S_CALL;
      end
      S_A6: begin
        if (sum > SAT_A) begin
          ach_d = '1;
        end else begin
          ach_d = RATE_W'(sum[KHZ_W-1:0]) * RATE_W'(KHZ_FACTOR);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          ost_d   = rej_q;
          opd_d   = rej_q ? '0 : dp_q;
          ofb_d   = rej_q ? '0 : dnf_q[FB_DIV_WIDTH-1:0];
          orf_d   = rej_q ? '0 : dmf_q;
          ofr_d   = rej_q ? '0 : frac_q;
          ofm_d   = !rej_q && (frac_q != '0);
          oach_d  = rej_q ? '0 : ach_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      ov_q    <= 1'b0;
      rej_q   <= 1'b0;
      opm_q   <= ALU_DIV;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
      rej_q   <= rej_d;
      opm_q   <= opm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    refraw_q <= refraw_d;
    rate_q   <= rate_d;
    refk_q   <= refk_d;
    dm_q     <= dm_d;
    dp_q     <= dp_d;
    vco_q    <= vco_d;
    ga_q     <= ga_d;
    gb_q     <= gb_d;
    dn_q     <= dn_d;
    sh_q     <= sh_d;
    k_q      <= k_d;
    dnf_q    <= dnf_d;
    dmf_q    <= dmf_d;
    frac_q   <= frac_d;
    acc_q    <= acc_d;
    ach_q    <= ach_d;
    ost_q    <= ost_d;
    ofm_q    <= ofm_d;
    opd_q    <= opd_d;
    ofb_q    <= ofb_d;
    orf_q    <= orf_d;
    ofr_q    <= ofr_d;
    oach_q   <= oach_d;
  end

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = ov_q;
  assign out_o.status           = ost_q;
  assign out_o.post_div         = opd_q;
  assign out_o.fb_div           = ofb_q;
  assign out_o.ref_div          = orf_q;
  assign out_o.frac_part        = ofr_q;
  assign out_o.frac_mode        = ofm_q;
  assign out_o.achieved_rate_hz = oach_q;

  a_wait_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT |-> (alu_stat.busy || alu_stat.done))
    else $error("sequencer waits on an idle ALU");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> out_o.post_div == '0 && out_o.fb_div == '0 &&
      out_o.ref_div == '0 && out_o.frac_part == '0 && out_o.achieved_rate_hz == '0)
    else $error("rejected beat carries nonzero fields");

  a_post_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.status |-> out_o.post_div != '0 && out_o.ref_div != '0)
    else $error("valid beat with zero divider");

  a_frac_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.frac_mode == (out_o.frac_part != '0))
    else $error("frac_mode disagrees with frac_part");

endmodule

>>> tb/pds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider solver checker
// Tracks the limit registers, predicts the dividers for every accepted
// request and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module pds_checker import pds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pds_in_if                     req_mon,
  pds_out_if                    res_mon,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    logic        status;
    logic [2:0]  post_div;
    logic [10:0] fb_div;
    logic [5:0]  ref_div;
    logic [23:0] frac_part;
    logic        frac_mode;
    logic [31:0] achieved_rate_hz;
  } solution_t;

  logic [LIM_W-1:0]  vco_low_khz;
  logic [LIM_W-1:0]  vco_high_khz;
  logic [STEP_W-1:0] ref_step_khz;
  solution_t         pending_solutions[$];

  function automatic solution_t solve_dividers(logic [31:0] target_hz, logic [31:0] ref_hz);
    solution_t   s;
    logic [63:0] rate, refk, dp, vco, a, b, t, dn, dm, dmt, num, q, r, frac, ach;
    s = '0;
    s.status = 1'b1;
    frac = 0;
    rate = target_hz / KHZ_FACTOR;
    refk = ref_hz / KHZ_FACTOR;
    if (rate == 0 || refk == 0) return s;
    if (rate > vco_high_khz) return s;
    if (rate < vco_low_khz) begin
      dp = vco_low_khz / rate + 1;
      if (dp > POST_DIV_MAX) return s;
      vco = rate * dp;
    end else begin
      dp = 1;
      vco = rate;
    end
    a = vco;
    b = refk;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    dn = vco / a;
    dm = refk / a;
    if (dm > 63 || dn > 2047) begin
      if (dn / dm > 2047) return s;
      dmt = 1;
      while (dmt < 31 && (dn * dmt / dm) < 1023 && refk >= ref_step_khz * dmt)
        dmt = dmt * 2;
      num  = dn * dmt;
      q    = num / dm;
      r    = num % dm;
      frac = (r << 24) / dm;
      dn   = q;
      dm   = dmt;
    end
    ach = refk * dn / dm / dp;
    if (frac != 0) ach = ach + ((refk * frac / dm / dp) >> 24);
    ach = ach * KHZ_FACTOR;
    if (ach > 64'hFFFF_FFFF) ach = 64'hFFFF_FFFF;
    s.status           = 1'b0;
    s.post_div         = dp[2:0];
    s.fb_div           = dn[10:0];
    s.ref_div          = dm[5:0];
    s.frac_part        = frac[23:0];
    s.frac_mode        = (frac != 0);
    s.achieved_rate_hz = ach[31:0];
    return s;
  endfunction

  assign pending_o = pending_solutions.size();

  always @(posedge clk_i or negedge rst_ni) begin
    solution_t got, exp_s;
    if (!rst_ni) begin
      vco_low_khz  <= VCO_LOW_RST;
      vco_high_khz <= VCO_HIGH_RST;
      ref_step_khz <= REF_STEP_RST;
      errors_o     <= 0;
      pending_solutions.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VCO_LOW:  vco_low_khz  <= cfg_data_i[LIM_W-1:0];
          CFG_VCO_HIGH: vco_high_khz <= cfg_data_i[LIM_W-1:0];
          CFG_REF_STEP: ref_step_khz <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        pending_solutions.push_back(solve_dividers(req_mon.target_rate_hz,
                                                   req_mon.ref_rate_hz));
      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.status, res_mon.post_div, res_mon.fb_div, res_mon.ref_div,
               res_mon.frac_part, res_mon.frac_mode, res_mon.achieved_rate_hz};
        if (pending_solutions.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          exp_s = pending_solutions.pop_front();
          if (got != exp_s) begin
            $display("%0t: mismatch expected st=%0d dp=%0d dn=%0d dm=%0d fr=%0d fm=%0d hz=%0d",
                     $time, exp_s.status, exp_s.post_div, exp_s.fb_div, exp_s.ref_div,
                     exp_s.frac_part, exp_s.frac_mode, exp_s.achieved_rate_hz);
            $display("%0t:          actual   st=%0d dp=%0d dn=%0d dm=%0d fr=%0d fm=%0d hz=%0d",
                     $time, got.status, got.post_div, got.fb_div, got.ref_div,
                     got.frac_part, got.frac_mode, got.achieved_rate_hz);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider solver testbench
// Drives directed and random rate requests over several limit settings with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import pds_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_VCO_LOW;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  no_idle = 1'b0;
  int                    errors;
  int                    pending;

  pds_in_if  in_if();
  pds_out_if out_if();

  pll_divider_solver uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_if), .out_o(out_if)
  );

  pds_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_mon(in_if), .res_mon(out_if), .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.target_rate_hz = '0;
    in_if.ref_rate_hz = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i)
    out_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 29);

  task automatic send_request(logic [31:0] tgt, logic [31:0] rf);
    in_if.valid          <= 1'b1;
    in_if.target_rate_hz <= tgt;
    in_if.ref_rate_hz    <= rf;
    do @(posedge clk_i); while (!in_if.ready);
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [21:0] lo, logic [21:0] hi, logic [19:0] step);
    drain();
    repeat (1100) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_VCO_LOW;  cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i <= CFG_VCO_HIGH; cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i <= CFG_REF_STEP; cfg_data_i <= {2'b00, step};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_requests(int n);
    logic [31:0] tgt, rf;
    int          sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin tgt = $urandom; rf = $urandom; end
        8: begin
          tgt = $urandom_range(100000, 3300000) * 1000 + $urandom_range(0, 999);
          case ($urandom_range(0, 3))
            0: rf = 24000000;
            1: rf = 25000000;
            2: rf = 19200000;
            default: rf = 27000000;
          endcase
        end
        9: begin
          tgt = $urandom_range(0, 200000) * 1000 + $urandom_range(0, 999);
          rf  = $urandom_range(0, 200000) * 1000 + $urandom_range(0, 999);
        end
        default: begin
          tgt = $urandom_range(1, 3300000) * 1000 + $urandom_range(0, 999);
          rf  = $urandom_range(1000, 100000) * 1000 + $urandom_range(0, 999);
        end
      endcase
      send_request(tgt, rf);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, extremes, integer and fractional solutions
    send_request(32'd0, 32'd24000000);
    send_request(32'd1200000000, 32'd0);
    send_request(32'd999, 32'd24000000);
    send_request(32'd1200000000, 32'd999);
    send_request(32'd3200001000, 32'd24000000);
    send_request(32'd3200000000, 32'd24000000);
    send_request(32'd100000000, 32'd24000000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd1200000000, 32'hFFFF_FFFF);
    send_request(32'd1200000000, 32'd24000000);
    send_request(32'd1000001000, 32'd24000000);
    send_request(32'd3200000000, 32'd1000000);
    send_request(32'd2999999999, 32'd27000000);
    send_request(32'd600000000, 32'd19200000);
    send_request(32'd114285000, 32'd25000000);
    send_request(32'd799999000, 32'd1000);
    send_request(32'd1234567000, 32'd12345000);
    random_requests(150);

    // pause the sender until every result is out
    drain();
    random_requests(50);

    set_limits(22'd1, 22'h3F_FFFF, 20'd1);
    send_request(32'hFFFF_FFFF, 32'd1000);
    send_request(32'd1000, 32'd1000);
    random_requests(100);

    set_limits(22'h3F_FFFF, 22'h3F_FFFF, 20'hF_FFFF);
    no_idle <= 1'b1;
    random_requests(100);
    no_idle <= 1'b0;

    set_limits(22'd0, 22'd0, 20'd0);
    random_requests(20);
    set_limits(22'd0, 22'h3F_FFFF, 20'd0);
    random_requests(60);

    set_limits(22'd500000, 22'd2000000, 20'd5000);
    random_requests(100);

    drain();
    repeat (1100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pds_pkg.sv
rtl/core/pds_in_if.sv
rtl/core/pds_out_if.sv
rtl/core/pds_serial_alu.sv
rtl/core/pll_divider_solver.sv
tb/pds_checker.sv
tb/tb_top.sv
